// ===== hdl/assert_macros.svh =====
// Assertion helpers shared by the RTL. Every use samples on clk_i and is
// switched off while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SFS_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SFS_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/sfs_pkg.sv =====
package sfs_pkg;

  // Default sizes.
  localparam int SampleBits    = 16;
  localparam int PhaseBits     = 32;
  localparam int SineTableBits = 10;

  // Smoother state is Q1.23 whatever the sample width.
  localparam int SecBits   = 24;
  localparam int NumLanes  = 2;

  // Q16 smoothing coefficients (0.6413 and 0.9260).
  localparam int CoefA = 42028;
  localparam int CoefB = 60686;

  localparam longint HalfPiQ30 = 64'd1686629713;
  localparam int OneQ15        = 32768;
  localparam int KnobCenter    = 16384;
  localparam int ShiftScale    = 1000;

  // Configuration port.
  localparam int CfgIdxBits  = 2;
  localparam int CfgDataBits = 18;
  localparam int KnobBits    = 16;
  localparam int RateBits    = 18;
  localparam int GainBits    = 17;

  typedef enum logic [CfgIdxBits-1:0] {
    CfgEnable = 2'd0,
    CfgShift  = 2'd1,
    CfgMix    = 2'd2,
    CfgRate   = 2'd3
  } cfg_idx_e;

  // Stage strobes and the enable flag from the sequencer to every lane.
  typedef struct packed {
    logic load;
    logic mul1;
    logic mul2;
    logic prod;
    logic mix;
    logic enable;
  } lane_ctrl_t;

  // Quarter-wave sine entry m of a table with 2^tb entries, Q1.15.
  // Evaluated at elaboration only, to fill the constant table.
  function automatic logic [14:0] quarter_sine(input int unsigned m, input int unsigned tb);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    x    = (64'(m) * 64'(HalfPiQ30) + (64'd1 << (tb - 3))) >> (tb - 2);
    x2   = (x * x) >> 30;
    term = x;
    sum  = signed'(x);
    term = ((term * x2) >> 30) / 64'd6;
    sum  = sum - signed'(term);
    term = ((term * x2) >> 30) / 64'd20;
    sum  = sum + signed'(term);
    term = ((term * x2) >> 30) / 64'd42;
    sum  = sum - signed'(term);
    term = ((term * x2) >> 30) / 64'd72;
    sum  = sum + signed'(term);
    term = ((term * x2) >> 30) / 64'd110;
    sum  = sum - signed'(term);
    term = ((term * x2) >> 30) / 64'd156;
    sum  = sum + signed'(term);
    term = ((term * x2) >> 30) / 64'd210;
    sum  = sum - signed'(term);
    if (sum < 0) begin
      sum = 0;
    end
    sum = (sum + 64'sd16384) >>> 15;
    if (sum > 64'sd32767) begin
      sum = 64'sd32767;
    end
    return 15'(sum);
  endfunction

endpackage

// ===== hdl/sfs_in_if.sv =====
interface sfs_in_if #(
  parameter int SAMPLE_BITS = sfs_pkg::SampleBits
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] left_in;
  logic signed [SAMPLE_BITS-1:0] right_in;

  modport source (output valid, output left_in, output right_in, input ready);
  modport sink   (input valid, input left_in, input right_in, output ready);
endinterface

// ===== hdl/sfs_out_if.sv =====
interface sfs_out_if #(
  parameter int SAMPLE_BITS = sfs_pkg::SampleBits
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] left_out;
  logic signed [SAMPLE_BITS-1:0] right_out;

  modport source (output valid, output left_out, output right_out, input ready);
  modport sink   (input valid, input left_out, input right_out, output ready);
endinterface

// ===== hdl/sfs_step_div.sv =====
// Derives the oscillator phase increment from the knob and the sample rate
// with a restoring divider that produces one quotient bit per cycle.
module sfs_step_div #(
  parameter int PHASE_BITS = sfs_pkg::PhaseBits
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              kick_i,
  input  logic [sfs_pkg::KnobBits-1:0]      shift_i,
  input  logic [sfs_pkg::RateBits-1:0]      rate_i,
  output logic                              busy_o,
  output logic [PHASE_BITS-1:0]             step_o
);

  localparam int KnobW  = sfs_pkg::KnobBits;
  localparam int RateW  = sfs_pkg::RateBits;
  localparam int ProdW  = KnobW + 10;
  localparam int DvdW   = PHASE_BITS + 12;
  localparam int CntW   = $clog2(DvdW);

  typedef enum logic [1:0] {
    DV_IDLE,
    DV_LOAD,
    DV_RUN,
    DV_DONE
  } dv_state_e;

  dv_state_e          state_q;
  logic               pend_q;
  logic               neg_q;
  logic [RateW-1:0]   sr_q;
  logic [RateW-1:0]   rem_q;
  logic [DvdW-1:0]    dvd_q;
  logic [PHASE_BITS-1:0] quo_q;
  logic [PHASE_BITS-1:0] step_q;
  logic [CntW-1:0]    cnt_q;

  logic [KnobW:0]     diff;
  logic               neg;
  logic [KnobW-1:0]   mag;
  logic [ProdW-1:0]   prod;
  logic [RateW-1:0]   sr;
  logic [DvdW-1:0]    dividend;
  logic [RateW:0]     rem_ext;
  logic               ge;
  logic [RateW:0]     rem_nxt;

  always_comb begin
    diff     = (KnobW + 1)'(shift_i) - (KnobW + 1)'(sfs_pkg::KnobCenter);
    neg      = diff[KnobW];
    mag      = neg ? KnobW'(-diff) : diff[KnobW-1:0];
    prod     = ProdW'(mag) * ProdW'(sfs_pkg::ShiftScale);
    sr       = (rate_i == '0) ? RateW'(1) : rate_i;
    dividend = (DvdW'(prod) << (PHASE_BITS - 15)) + DvdW'(sr >> 1);
    rem_ext  = {rem_q, dvd_q[DvdW-1]};
    ge       = rem_ext >= {1'b0, sr_q};
    rem_nxt  = ge ? (rem_ext - {1'b0, sr_q}) : rem_ext;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DV_IDLE;
      pend_q  <= 1'b1;
      neg_q   <= 1'b0;
      sr_q    <= '0;
      rem_q   <= '0;
      dvd_q   <= '0;
      quo_q   <= '0;
      step_q  <= '0;
      cnt_q   <= '0;
    end else begin
      if (kick_i) begin
        pend_q <= 1'b1;
      end
      unique case (state_q)
        DV_IDLE: begin
          if (pend_q && !kick_i) begin
            pend_q  <= 1'b0;
            state_q <= DV_LOAD;
          end
        end
        DV_LOAD: begin
          neg_q   <= neg;
          sr_q    <= sr;
          rem_q   <= '0;
          dvd_q   <= dividend;
          quo_q   <= '0;
          cnt_q   <= CntW'(DvdW - 1);
          state_q <= DV_RUN;
        end
        DV_RUN: begin
          rem_q <= rem_nxt[RateW-1:0];
          dvd_q <= {dvd_q[DvdW-2:0], 1'b0};
          quo_q <= {quo_q[PHASE_BITS-2:0], ge};
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == '0) begin
            state_q <= DV_DONE;
          end
        end
        DV_DONE: begin
          // Only the low phase bits of the step matter, the accumulator wraps.
          step_q  <= neg_q ? (~quo_q + 1'b1) : quo_q;
          state_q <= DV_IDLE;
        end
        default: state_q <= DV_IDLE;
      endcase
    end
  end

  assign busy_o = pend_q || (state_q != DV_IDLE);
  assign step_o = step_q;

endmodule

// ===== hdl/sfs_lane.sv =====
// One channel: two cascaded smoothers, phase accumulator with sine lookup,
// quadrature product and dry/wet blend; multiplies in mul1, mul2, prod, mix.
module sfs_lane #(
  parameter int SAMPLE_BITS     = sfs_pkg::SampleBits,
  parameter int PHASE_BITS      = sfs_pkg::PhaseBits,
  parameter int SINE_TABLE_BITS = sfs_pkg::SineTableBits
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  sfs_pkg::lane_ctrl_t                 ctrl_i,
  input  logic signed [SAMPLE_BITS-1:0]       sample_i,
  input  logic [PHASE_BITS-1:0]               step_i,
  input  logic [sfs_pkg::GainBits-1:0]        wet_gain_i,
  input  logic [sfs_pkg::GainBits-1:0]        dry_gain_i,
  output logic signed [SAMPLE_BITS-1:0]       result_o
);

  localparam int SecW    = sfs_pkg::SecBits;
  localparam int GainW   = sfs_pkg::GainBits;
  localparam int TrigW   = 17;
  localparam int P1W     = SecW + 1 + TrigW;
  localparam int ProdW   = SecW + TrigW;
  localparam int WetW    = SecW + 2;
  localparam int DryW    = SecW + GainW + 1;
  localparam int MixW    = WetW + GainW + 1;
  localparam int TotW    = MixW + 1;
  localparam int OutSh   = 15 + SecW - SAMPLE_BITS;
  localparam int Quarter = 1 << (SINE_TABLE_BITS - 2);
  localparam int QIdxW   = SINE_TABLE_BITS - 1;
  localparam longint SatMax = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
  localparam longint SatMin = -(longint'(1) << (SAMPLE_BITS - 1));

  logic [14:0] qsin [Quarter+1];

  for (genvar k = 0; k <= Quarter; k++) begin : g_qsin
    assign qsin[k] = sfs_pkg::quarter_sine(k, SINE_TABLE_BITS);
  end

  // Smoother state and oscillator phase.
  logic signed [SecW-1:0] z1_q;
  logic signed [SecW-1:0] z2_q;
  logic [PHASE_BITS-1:0]  phase_q;

  // Stage registers.
  logic signed [SecW-1:0]  x_q;
  logic signed [P1W-1:0]   p1_q;
  logic signed [P1W-1:0]   p2_q;
  logic signed [TrigW-1:0] sin_q;
  logic signed [TrigW-1:0] cos_q;
  logic signed [ProdW-1:0] pc_q;
  logic signed [ProdW-1:0] ps_q;
  logic signed [DryW-1:0]  pd_q;
  logic signed [MixW-1:0]  pw_q;

  logic signed [TrigW-1:0] coef_a;
  logic signed [TrigW-1:0] coef_b;
  logic signed [SecW:0]    d1;
  logic signed [SecW:0]    d2;
  logic signed [P1W-1:0]   r1;
  logic signed [P1W-1:0]   r2;
  logic signed [SecW-1:0]  y1;
  logic signed [SecW-1:0]  y2;
  logic signed [ProdW:0]   wsum;
  logic signed [WetW-1:0]  wet;
  logic signed [GainW:0]   wet_gain_s;
  logic signed [GainW:0]   dry_gain_s;
  logic signed [TotW-1:0]  tot;
  logic signed [TotW-1:0]  tot_sh;
  logic signed [SAMPLE_BITS-1:0] sat;
  logic [SINE_TABLE_BITS-1:0] tidx [2];
  logic signed [TrigW-1:0]    tval [2];

  always_comb begin
    coef_a     = TrigW'(sfs_pkg::CoefA);
    coef_b     = TrigW'(sfs_pkg::CoefB);
    d1         = (SecW + 1)'(x_q) - (SecW + 1)'(z1_q);
    r1         = p1_q + P1W'(32768);
    y1         = z1_q + SecW'(r1 >>> 16);
    d2         = (SecW + 1)'(y1) - (SecW + 1)'(z2_q);
    r2         = p2_q + P1W'(32768);
    y2         = z2_q + SecW'(r2 >>> 16);
    wsum       = (ProdW + 1)'(pc_q) - (ProdW + 1)'(ps_q) + (ProdW + 1)'(16384);
    wet        = WetW'(wsum >>> 15);
    wet_gain_s = $signed({1'b0, wet_gain_i});
    dry_gain_s = $signed({1'b0, dry_gain_i});
    tot        = TotW'(pd_q) + TotW'(pw_q) + (TotW'(1) <<< (OutSh - 1));
    tot_sh     = tot >>> OutSh;
    if (tot_sh > TotW'(SatMax)) begin
      sat = SAMPLE_BITS'(SatMax);
    end else if (tot_sh < TotW'(SatMin)) begin
      sat = SAMPLE_BITS'(SatMin);
    end else begin
      sat = SAMPLE_BITS'(tot_sh);
    end
  end

  // Sine uses the phase index, cosine the index a quarter wave ahead.
  always_comb begin
    logic [1:0]       quad;
    logic [QIdxW-1:0] rel;
    logic [QIdxW-1:0] addr;
    logic [14:0]      mag;
    tidx[0] = phase_q[PHASE_BITS-1 -: SINE_TABLE_BITS];
    tidx[1] = tidx[0] + SINE_TABLE_BITS'(Quarter);
    for (int i = 0; i < 2; i++) begin
      quad    = tidx[i][SINE_TABLE_BITS-1 -: 2];
      rel     = QIdxW'(tidx[i][SINE_TABLE_BITS-3:0]);
      addr    = quad[0] ? (QIdxW'(Quarter) - rel) : rel;
      mag     = qsin[addr];
      tval[i] = quad[1] ? -$signed({2'b00, mag}) : $signed({2'b00, mag});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      z1_q    <= '0;
      z2_q    <= '0;
      phase_q <= '0;
    end else begin
      if (ctrl_i.load && ctrl_i.enable) begin
        phase_q <= phase_q + step_i;
      end
      if (ctrl_i.mul2 && ctrl_i.enable) begin
        z1_q <= y1;
      end
      if (ctrl_i.prod && ctrl_i.enable) begin
        z2_q <= y2;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      x_q <= SecW'(sample_i) <<< (SecW - SAMPLE_BITS);
    end
    if (ctrl_i.mul1) begin
      p1_q  <= d1 * coef_a;
      sin_q <= tval[0];
      cos_q <= tval[1];
    end
    if (ctrl_i.mul2) begin
      p2_q <= d2 * coef_b;
    end
    if (ctrl_i.prod) begin
      pc_q <= x_q * cos_q;
      ps_q <= y2 * sin_q;
    end
    if (ctrl_i.mix) begin
      pd_q <= x_q * dry_gain_s;
      pw_q <= wet * wet_gain_s;
    end
  end

  // When disabled the original sample comes back bit for bit.
  assign result_o = ctrl_i.enable ? sat : x_q[SecW-1 -: SAMPLE_BITS];

endmodule

// ===== hdl/sfs_merge.sv =====
// Collects the lane results into one output frame and holds it until the
// receiver takes it.
module sfs_merge #(
  parameter int SAMPLE_BITS = sfs_pkg::SampleBits
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          capture_i,
  input  logic signed [SAMPLE_BITS-1:0] lane_res_i [sfs_pkg::NumLanes],
  output logic                          free_o,
  sfs_out_if.source                     out_o
);

  logic                          valid_q;
  logic signed [SAMPLE_BITS-1:0] left_q;
  logic signed [SAMPLE_BITS-1:0] right_q;
  logic                          take;

  assign free_o = !valid_q || out_o.ready;
  assign take   = capture_i && free_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (take) begin
      valid_q <= 1'b1;
    end else if (out_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      left_q  <= lane_res_i[0];
      right_q <= lane_res_i[1];
    end
  end

  assign out_o.valid     = valid_q;
  assign out_o.left_out  = left_q;
  assign out_o.right_out = right_q;

endmodule

// ===== hdl/stereo_frequency_shifter.sv =====
// Stereo frequency shifter: each input item is one stereo frame (left_in,
// right_in) on in_i; each output item on out_o is the shifted frame.
// Both channels are processed side by side by two identical lanes.
// Configuration is written through cfg_we_i / cfg_idx_i / cfg_data_i:
// index 0 enable, 1 shift knob, 2 wet mix, 3 sample rate.
// An accepted frame passes ST_MUL1, ST_MUL2, ST_PROD, ST_MIX and ST_OUT, and
// out_o.valid rises when ST_OUT hands it to the output register. A new frame
// is taken only in ST_IDLE, once the last has passed the four multiply stages
// of a lane (two smoothers, quadrature product, blend) and capture. The phase
// increment comes from a bit-serial divider; after reset and after every write
// of the shift knob or the sample rate it runs with in_i.ready held low.
// Reset clears the smoother states, the oscillator phases and the output
// valid, loads the register defaults and starts the divider.
// If the receiver stalls, the finished frame waits in the output register
// while the next frame may still be accepted and computed; that frame then
// waits at its last stage until the output register frees up.
`include "assert_macros.svh"

module stereo_frequency_shifter #(
  parameter int SAMPLE_BITS     = sfs_pkg::SampleBits,
  parameter int PHASE_BITS      = sfs_pkg::PhaseBits,
  parameter int SINE_TABLE_BITS = sfs_pkg::SineTableBits
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [sfs_pkg::CfgIdxBits-1:0]     cfg_idx_i,
  input  logic [sfs_pkg::CfgDataBits-1:0]    cfg_data_i,
  sfs_in_if.sink                             in_i,
  sfs_out_if.source                          out_o
);

  localparam int GainW = sfs_pkg::GainBits;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_PROD,
    ST_MIX,
    ST_OUT
  } state_e;

  state_e                         state_q;
  logic                           en_q;
  logic [sfs_pkg::KnobBits-1:0]   shift_q;
  logic [sfs_pkg::KnobBits-1:0]   mix_q;
  logic [sfs_pkg::RateBits-1:0]   rate_q;

  logic                           div_busy;
  logic                           div_kick;
  logic [PHASE_BITS-1:0]          step;
  logic                           accept;
  logic                           merge_free;
  logic [GainW-1:0]               wet_gain;
  logic [GainW-1:0]               dry_gain;
  sfs_pkg::lane_ctrl_t            ctrl;
  logic signed [SAMPLE_BITS-1:0]  lane_in  [sfs_pkg::NumLanes];
  logic signed [SAMPLE_BITS-1:0]  lane_res [sfs_pkg::NumLanes];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q    <= 1'b0;
      shift_q <= sfs_pkg::KnobBits'(sfs_pkg::KnobCenter);
      mix_q   <= sfs_pkg::KnobBits'(sfs_pkg::OneQ15);
      rate_q  <= sfs_pkg::RateBits'(48000);
    end else if (cfg_we_i) begin
      unique case (sfs_pkg::cfg_idx_e'(cfg_idx_i))
        sfs_pkg::CfgEnable: en_q    <= cfg_data_i[0];
        sfs_pkg::CfgShift:  shift_q <= cfg_data_i[sfs_pkg::KnobBits-1:0];
        sfs_pkg::CfgMix:    mix_q   <= cfg_data_i[sfs_pkg::KnobBits-1:0];
        sfs_pkg::CfgRate:   rate_q  <= cfg_data_i[sfs_pkg::RateBits-1:0];
        default: ;
      endcase
    end
  end

  assign div_kick = cfg_we_i && (cfg_idx_i == sfs_pkg::CfgShift ||
                                 cfg_idx_i == sfs_pkg::CfgRate);

  sfs_step_div #(
    .PHASE_BITS (PHASE_BITS)
  ) u_step_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .kick_i  (div_kick),
    .shift_i (shift_q),
    .rate_i  (rate_q),
    .busy_o  (div_busy),
    .step_o  (step)
  );

  // A mix setting above full scale counts as fully wet.
  assign wet_gain = (mix_q > sfs_pkg::KnobBits'(sfs_pkg::OneQ15)) ?
                    GainW'(sfs_pkg::OneQ15) : GainW'(mix_q);
  assign dry_gain = GainW'(sfs_pkg::OneQ15) - wet_gain;

  assign in_i.ready = (state_q == ST_IDLE) && !div_busy;
  assign accept     = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      unique case (state_q)
        ST_IDLE: if (accept) begin
          state_q <= ST_MUL1;
        end
        ST_MUL1: state_q <= ST_MUL2;
        ST_MUL2: state_q <= ST_PROD;
        ST_PROD: state_q <= ST_MIX;
        ST_MIX:  state_q <= ST_OUT;
        ST_OUT: if (merge_free) begin
          state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_comb begin
    ctrl.load   = accept;
    ctrl.mul1   = state_q == ST_MUL1;
    ctrl.mul2   = state_q == ST_MUL2;
    ctrl.prod   = state_q == ST_PROD;
    ctrl.mix    = state_q == ST_MIX;
    ctrl.enable = en_q;
  end

  assign lane_in[0] = in_i.left_in;
  assign lane_in[1] = in_i.right_in;

  for (genvar ln = 0; ln < sfs_pkg::NumLanes; ln++) begin : g_lane
    sfs_lane #(
      .SAMPLE_BITS     (SAMPLE_BITS),
      .PHASE_BITS      (PHASE_BITS),
      .SINE_TABLE_BITS (SINE_TABLE_BITS)
    ) u_lane (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .sample_i   (lane_in[ln]),
      .step_i     (step),
      .wet_gain_i (wet_gain),
      .dry_gain_i (dry_gain),
      .result_o   (lane_res[ln])
    );
  end

  sfs_merge #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_merge (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .capture_i  (state_q == ST_OUT),
    .lane_res_i (lane_res),
    .free_o     (merge_free),
    .out_o      (out_o)
  );

  `SFS_ASSERT_IMP(a_no_accept_while_div, in_i.valid && in_i.ready, !div_busy, "item taken during step update")
  `SFS_ASSERT_NXT(a_accept_starts_lanes, in_i.valid && in_i.ready, state_q == ST_MUL1, "accepted item did not start")
  `SFS_ASSERT_NXT(a_out_waits_for_free, state_q == ST_OUT && !merge_free, state_q == ST_OUT, "result dropped while output full")
  `SFS_ASSERT_NXT(a_knob_write_recalc, cfg_we_i && cfg_idx_i == sfs_pkg::CfgShift, div_busy, "knob write did not restart step update")

endmodule

// ===== verif/stereo_frequency_shifter_tb.sv =====
module stereo_frequency_shifter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SampleBits   = sfs_pkg::SampleBits;
  localparam int PhaseBits    = sfs_pkg::PhaseBits;
  localparam int TableBits    = sfs_pkg::SineTableBits;
  localparam int QuarterSteps = 1 << (TableBits - 2);
  localparam int LagBits      = sfs_pkg::SecBits - SampleBits;
  localparam int OutShift     = 15 + LagBits;
  localparam int QuietLimit   = 5000;
  localparam int DrainCycles  = 20;
  localparam int HoldCycles   = 400;
  localparam int RandPhases   = 8;
  localparam int PhaseItems   = 160;

  typedef struct packed {
    logic signed [SampleBits-1:0] left_s;
    logic signed [SampleBits-1:0] right_s;
  } frame_t;

  logic                               clk_i;
  logic                               rst_ni;
  logic                               cfg_we;
  logic [sfs_pkg::CfgIdxBits-1:0]     cfg_idx;
  logic [sfs_pkg::CfgDataBits-1:0]    cfg_data;

  sfs_in_if  in_if ();
  sfs_out_if out_if ();

  stereo_frequency_shifter dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  // Shadow of the block's registers and state, used by the predictor.
  logic                          cur_enable;
  logic [sfs_pkg::KnobBits-1:0]  cur_knob;
  logic [sfs_pkg::KnobBits-1:0]  cur_mix;
  logic [sfs_pkg::RateBits-1:0]  cur_rate;
  logic [PhaseBits-1:0]          osc_acc [2];
  longint                        stage1 [2];
  longint                        stage2 [2];

  frame_t frames_q [$];
  frame_t shifted_q [$];

  int  err_cnt;
  int  outputs_seen;
  int  quiet_cycles;
  bit  in_taken;

  initial begin
    clk_i = 1'b0;
    forever begin
      #6 clk_i = ~clk_i;
    end
  end

  // Sine of m quarter-wave steps (m in 0..QuarterSteps), Q1.15, from a Taylor series in Q30.
  function automatic longint quarter_wave(input longint unsigned m);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          acc;
    int              n;
    x    = (m * longint'(sfs_pkg::HalfPiQ30) + QuarterSteps / 2) / QuarterSteps;
    x2   = (x * x) >> 30;
    term = x;
    acc  = longint'(x);
    for (n = 1; n <= 7; n++) begin
      term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) begin
        acc = acc - longint'(term);
      end else begin
        acc = acc + longint'(term);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    acc = (acc + 16384) >>> 15;
    if (acc > 32767) begin
      acc = 32767;
    end
    return acc;
  endfunction

  function automatic longint wave_sine(input int idx);
    int     q;
    int     r;
    longint v;
    idx = idx & ((1 << TableBits) - 1);
    q   = idx / QuarterSteps;
    r   = idx % QuarterSteps;
    v   = (q % 2 == 1) ? quarter_wave(QuarterSteps - r) : quarter_wave(r);
    return (q >= 2) ? -v : v;
  endfunction

  function automatic longint smooth_next(input longint x, input longint z, input longint c);
    return z + ((c * (x - z) + 64'sd32768) >>> 16);
  endfunction

  function automatic logic signed [SampleBits-1:0] shift_lane(
    input logic signed [SampleBits-1:0] sample_v,
    input int                           lane
  );
    longint x24;
    longint y1;
    longint y2;
    longint diff;
    longint mag;
    longint rate;
    longint step;
    longint sn;
    longint cs;
    longint wet;
    longint wet_amt;
    longint total;
    int     idx;
    if (!cur_enable) begin
      return sample_v;
    end
    x24 = longint'(sample_v) * (64'sd1 <<< LagBits);
    y1 = smooth_next(x24, stage1[lane], sfs_pkg::CoefA);
    stage1[lane] = y1;
    y2 = smooth_next(y1, stage2[lane], sfs_pkg::CoefB);
    stage2[lane] = y2;

    diff = longint'(cur_knob) - sfs_pkg::KnobCenter;
    mag  = (diff < 0) ? -diff : diff;
    rate = (cur_rate == '0) ? 64'sd1 : longint'(cur_rate);
    step = (((mag * sfs_pkg::ShiftScale) <<< (PhaseBits - 15)) + rate / 2) / rate;
    if (diff < 0) begin
      step = -step;
    end
    osc_acc[lane] = osc_acc[lane] + step[PhaseBits-1:0];

    idx = int'(osc_acc[lane][PhaseBits-1 -: TableBits]);
    sn  = wave_sine(idx);
    cs  = wave_sine(idx + QuarterSteps);
    wet = (x24 * cs - y2 * sn + 64'sd16384) >>> 15;

    wet_amt = (cur_mix > sfs_pkg::OneQ15) ? longint'(sfs_pkg::OneQ15) : longint'(cur_mix);
    total = x24 * (sfs_pkg::OneQ15 - wet_amt) + wet * wet_amt;
    total = (total + (64'sd1 <<< (OutShift - 1))) >>> OutShift;
    if (total > 32767) begin
      total = 32767;
    end
    if (total < -32768) begin
      total = -32768;
    end
    return total[SampleBits-1:0];
  endfunction

  // Input acceptance: the predictor runs here, in item order.
  always @(posedge clk_i) begin
    frame_t in_f;
    frame_t out_f;
    in_taken = rst_ni && in_if.valid && in_if.ready;
    if (in_taken) begin
      in_f.left_s  = in_if.left_in;
      in_f.right_s = in_if.right_in;
      out_f.left_s  = shift_lane(in_f.left_s, 0);
      out_f.right_s = shift_lane(in_f.right_s, 1);
      shifted_q.push_back(out_f);
      void'(frames_q.pop_front());
    end
  end

  // Sender: bursts of random length separated by random gaps.
  always @(negedge clk_i) begin
    int burst_left;
    int gap_left;
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else if (in_if.valid && !in_taken) begin
      // Item still on offer; hold it.
    end else if (gap_left > 0) begin
      gap_left--;
      in_if.valid <= 1'b0;
    end else if (frames_q.size() > 0) begin
      in_if.valid    <= 1'b1;
      in_if.left_in  <= frames_q[0].left_s;
      in_if.right_in <= frames_q[0].right_s;
      if (burst_left <= 1) begin
        burst_left = $urandom_range(1, 40);
        case ($urandom_range(0, 3))
          0, 1:    gap_left = 0;
          2:       gap_left = $urandom_range(1, 3);
          default: gap_left = $urandom_range(5, 30);
        endcase
      end else begin
        burst_left--;
      end
    end else begin
      in_if.valid <= 1'b0;
    end
  end

  // Receiver: a stall pattern that changes mode every so often, plus two long
  // hold-offs that let the block fill up and push back on its input.
  always @(negedge clk_i) begin
    int rx_mode;
    int rx_tick;
    int hold_left;
    int next_hold;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      rx_mode   = 0;
      rx_tick   = 0;
      hold_left = 0;
      next_hold = 300;
    end else begin
      rx_tick++;
      if (rx_tick % 64 == 0) begin
        rx_mode = $urandom_range(0, 3);
      end
      if (next_hold != 0 && outputs_seen >= next_hold) begin
        hold_left = HoldCycles;
        next_hold = (next_hold < 900) ? next_hold + 600 : 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        case (rx_mode)
          0:       out_if.ready <= 1'b1;
          1:       out_if.ready <= 1'($urandom_range(0, 1));
          2:       out_if.ready <= (rx_tick % 9) < 3;
          default: out_if.ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // Result checking against the oldest prediction.
  always @(posedge clk_i) begin
    frame_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      outputs_seen++;
      if (shifted_q.size() == 0) begin
        err_cnt++;
        $error("output item with nothing expected: left_out %0d right_out %0d",
               out_if.left_out, out_if.right_out);
      end else begin
        want = shifted_q.pop_front();
        if (out_if.left_out !== want.left_s) begin
          err_cnt++;
          $error("left_out: expected %0d, got %0d", want.left_s, out_if.left_out);
        end
        if (out_if.right_out !== want.right_s) begin
          err_cnt++;
          $error("right_out: expected %0d, got %0d", want.right_s, out_if.right_out);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || cfg_we) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("stereo_frequency_shifter verification failed");
      $finish;
    end
  end

  task automatic write_reg(input sfs_pkg::cfg_idx_e idx, input int unsigned value);
    @(negedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value[sfs_pkg::CfgDataBits-1:0];
    case (idx)
      sfs_pkg::CfgEnable: cur_enable = value[0];
      sfs_pkg::CfgShift:  cur_knob   = value[sfs_pkg::KnobBits-1:0];
      sfs_pkg::CfgMix:    cur_mix    = value[sfs_pkg::KnobBits-1:0];
      default:            cur_rate   = value[sfs_pkg::RateBits-1:0];
    endcase
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained(input int pause);
    while (frames_q.size() != 0 || shifted_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (pause) @(posedge clk_i);
  endtask

  // Registers change only once every frame in flight has come out.
  task automatic apply_settings(input int unsigned en, input int unsigned knob,
                                input int unsigned mix, input int unsigned rate);
    wait_drained(8);
    write_reg(sfs_pkg::CfgEnable, en);
    write_reg(sfs_pkg::CfgShift, knob);
    write_reg(sfs_pkg::CfgMix, mix);
    write_reg(sfs_pkg::CfgRate, rate);
    @(posedge clk_i);
  endtask

  task automatic push_frame(input int l, input int r);
    frame_t f;
    f.left_s  = l[SampleBits-1:0];
    f.right_s = r[SampleBits-1:0];
    frames_q.push_back(f);
  endtask

  function automatic int rand_sample();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return int'($signed(16'($urandom())));
      6: begin
        case ($urandom_range(0, 3))
          0:       return -32768;
          1:       return 32767;
          2:       return 0;
          default: return -1;
        endcase
      end
      7, 8:    return $urandom_range(0, 511) - 256;
      default: return ($urandom_range(0, 1) != 0) ? $urandom_range(30000, 32767)
                                                 : -$urandom_range(30000, 32768);
    endcase
  endfunction

  initial begin
    int          p;
    int          n;
    int          run;
    int          l;
    int          r;
    int unsigned en;
    int unsigned knob;
    int unsigned mix;
    int unsigned rate;

    in_if.valid    = 1'b0;
    in_if.left_in  = '0;
    in_if.right_in = '0;
    out_if.ready   = 1'b0;
    cfg_we         = 1'b0;
    cfg_idx        = sfs_pkg::CfgEnable;
    cfg_data       = '0;
    rst_ni         = 1'b0;
    err_cnt        = 0;
    outputs_seen   = 0;
    quiet_cycles   = 0;
    in_taken       = 1'b0;
    cur_enable     = 1'b0;
    cur_knob       = 16'd16384;
    cur_mix        = 16'd32768;
    cur_rate       = 18'd48000;
    for (p = 0; p < 2; p++) begin
      osc_acc[p] = '0;
      stage1[p]  = 0;
      stage2[p]  = 0;
    end
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);

    // Reset defaults: disabled, frames pass straight through.
    push_frame(-32768, 32767);
    push_frame(32767, -32768);
    push_frame(0, -1);

    // No shift, fully wet, full-scale swings to hit saturation.
    apply_settings(1, 16384, 32768, 48000);
    push_frame(32767, -32768);
    push_frame(32767, -32768);
    push_frame(32767, -32768);
    push_frame(-32768, 32767);
    push_frame(-32768, 32767);
    push_frame(0, 0);
    push_frame(1, -1);

    // Full upward shift at the lowest rate, mix above full scale.
    apply_settings(1, 32768, 40000, 8000);
    push_frame(32767, 32767);
    push_frame(32767, 32767);
    push_frame(-32768, -32768);
    push_frame(-32768, -32768);
    push_frame(12345, -12345);

    // Full downward shift, zero sample rate, fully dry.
    apply_settings(1, 0, 0, 0);
    push_frame(32767, -32768);
    push_frame(-32768, 32767);
    push_frame(100, -100);

    // Knob and mix at their register maximum, largest rate the port can hold.
    apply_settings(1, 65535, 65535, 262143);
    push_frame(32767, -32768);
    push_frame(32767, -32768);
    push_frame(-32768, 0);
    push_frame(0, 32767);

    // Disabled in the middle of a run: state must stay frozen.
    apply_settings(0, 20000, 16384, 192000);
    push_frame(5, 6);
    push_frame(-7, 8);

    for (p = 0; p < RandPhases; p++) begin
      en = (p == 5) ? 0 : (($urandom_range(0, 7) != 0) ? 1 : 0);
      case ($urandom_range(0, 5))
        0:       knob = 0;
        1:       knob = 16384;
        2:       knob = 32768;
        3:       knob = 65535;
        default: knob = $urandom_range(0, 32768);
      endcase
      case ($urandom_range(0, 4))
        0:       mix = 0;
        1:       mix = 32768;
        2:       mix = 65535;
        default: mix = $urandom_range(0, 32768);
      endcase
      case ($urandom_range(0, 6))
        0:       rate = 8000;
        1:       rate = 192000;
        2:       rate = 0;
        3:       rate = 262143;
        4:       rate = 48000;
        default: rate = $urandom_range(8000, 192000);
      endcase
      apply_settings(en, knob, mix, rate);
      n = 0;
      while (n < PhaseItems) begin
        if ($urandom_range(0, 3) == 0) begin
          // A held level lets the smoothers settle and the oscillator run.
          run = $urandom_range(4, 16);
          l   = rand_sample();
          r   = rand_sample();
          repeat (run) push_frame(l, r);
          n += run;
        end else begin
          push_frame(rand_sample(), rand_sample());
          n++;
        end
      end
    end

    wait_drained(DrainCycles);
    if (shifted_q.size() != 0) begin
      err_cnt++;
      $error("%0d expected output items never arrived", shifted_q.size());
    end
    if (err_cnt == 0) begin
      $display("stereo_frequency_shifter verification clean");
    end else begin
      $display("stereo_frequency_shifter verification failed");
    end
    $finish;
  end

endmodule
